// ===== rtl/sensor_frame_crc_check_and_scale_unit_defines.svh =====
// Assertion macros shared by the sensor frame checker RTL.
// Expects clk and rst in the scope of use; empty when SYNTH is defined.
`ifndef SENSOR_FRAME_CRC_CHECK_AND_SCALE_UNIT_DEFINES_SVH
`define SENSOR_FRAME_CRC_CHECK_AND_SCALE_UNIT_DEFINES_SVH
`ifndef SYNTH
// antecedent and consequent in the same cycle
`define SFCCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfccs assertion failed");
// consequent in the cycle after the antecedent
`define SFCCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfccs assertion failed");
`else
`define SFCCS_ASSERT_NOW(lbl, ante, cons)
`define SFCCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/sfccs_pkg.sv =====
// Types and constants for the sensor frame CRC check and scale unit.
// No dependencies.
package sfccs_pkg;

  localparam int QueueDepthDefault = 2;

  localparam logic [7:0]         CrcPoly    = 8'h31;
  localparam logic [7:0]         CrcInit    = 8'h00;
  localparam logic [15:0]        StatusMask = 16'h0003;
  localparam logic [14:0]        TempSpan   = 15'd17572;
  localparam logic [14:0]        HumSpan    = 15'd12500;
  localparam logic signed [15:0] TempOffset = -16'sd4685;
  localparam logic signed [15:0] HumOffset  = -16'sd600;

  typedef struct packed {
    logic       func;
    logic       frame_first;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic               measure_kind;
    logic [15:0]        raw_reading;
    logic signed [14:0] value_centi;
    logic               crc_ok;
  } out_item_t;

  // completed frame handed from front to back
  typedef struct packed {
    logic        kind;
    logic [15:0] raw;
    logic        crc_ok;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

// ===== rtl/sfccs_front.sv =====
// Front end: frame byte tracking and CRC-8 over the reading bytes.
// Depends on sfccs_pkg; pushes completed frames into sfccs_queue.
`include "sensor_frame_crc_check_and_scale_unit_defines.svh"
module sfccs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  sfccs_pkg::in_item_t frame_byte,
  input  logic              queue_full,
  output logic              push,
  output sfccs_pkg::job_t   push_job
);
  import sfccs_pkg::*;

  typedef enum logic [1:0] {
    IDX_MSB = 2'd0,
    IDX_LSB = 2'd1,
    IDX_CRC = 2'd2
  } byte_idx_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  byte_idx_t  byte_index;
  logic [7:0] high_byte;
  logic [7:0] low_byte;
  logic [7:0] crc_acc;
  logic       kind_latch;

  logic accept;
  logic take_msb;
  logic take_lsb;

  assign byte_stall = queue_full;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    take_msb = 1'b1;
    take_lsb = 1'b0;
    case (byte_index)
      IDX_LSB: begin
        take_msb = frame_byte.frame_first;
        take_lsb = !frame_byte.frame_first;
      end
      IDX_CRC: begin
        take_msb = frame_byte.frame_first;
      end
      default: begin
        take_msb = 1'b1;
      end
    endcase
  end

  assign push            = accept && !take_msb && !take_lsb;
  assign push_job.kind   = kind_latch;
  assign push_job.raw    = {high_byte, low_byte} & ~StatusMask;
  assign push_job.crc_ok = (crc_acc == frame_byte.data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= IDX_MSB;
      high_byte  <= '0;
      low_byte   <= '0;
      crc_acc    <= '0;
      kind_latch <= 1'b0;
    end else if (accept) begin
      if (take_msb) begin
        kind_latch <= frame_byte.func;
        high_byte  <= frame_byte.data_byte;
        crc_acc    <= crc8_step(CrcInit, frame_byte.data_byte);
        byte_index <= IDX_LSB;
      end else if (take_lsb) begin
        low_byte   <= frame_byte.data_byte;
        crc_acc    <= crc8_step(crc_acc, frame_byte.data_byte);
        byte_index <= IDX_CRC;
      end else begin
        byte_index <= IDX_MSB;
      end
    end
  end

  `SFCCS_ASSERT_NEXT(a_frame_restart, push, byte_index == IDX_MSB)
  `SFCCS_ASSERT_NOW(a_push_only_on_crc, push, byte_index == IDX_CRC && !frame_byte.frame_first)

endmodule

// ===== rtl/sfccs_queue.sv =====
// Short job queue between front and back; register-based storage.
// Depends on sfccs_pkg.
`include "sensor_frame_crc_check_and_scale_unit_defines.svh"
module sfccs_queue #(
  parameter int Depth = sfccs_pkg::QueueDepthDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  sfccs_pkg::job_t            push_job,
  input  logic                       pop,
  output sfccs_pkg::job_t            head_job,
  output sfccs_pkg::queue_status_t   status
);
  import sfccs_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  logic do_push;
  logic do_pop;

  assign status.valid = (count != '0);
  assign status.full  = (count == CntW'(Depth));
  assign head_job     = entries[rd_ptr];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SFCCS_ASSERT_NOW(a_count_bound, 1'b1, count <= CntW'(Depth))
  `SFCCS_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + 1'b1)

endmodule

// ===== rtl/sfccs_scale.sv =====
// Back end: scales the raw reading to hundredths, two register stages.
// Depends on sfccs_pkg; pops jobs from sfccs_queue.
`include "sensor_frame_crc_check_and_scale_unit_defines.svh"
module sfccs_scale (
  input  logic                     clk,
  input  logic                     rst,
  input  sfccs_pkg::queue_status_t q_status,
  input  sfccs_pkg::job_t          head_job,
  output logic                     pop,
  output logic                     result_valid,
  input  logic                     result_stall,
  output sfccs_pkg::out_item_t     result
);
  import sfccs_pkg::*;

  // stage 1: product
  logic        s1_valid;
  logic        s1_kind;
  logic [15:0] s1_raw;
  logic        s1_crc_ok;
  logic [30:0] s1_prod;

  logic               out_take;
  logic               s1_load;
  logic [14:0]        span;
  logic [14:0]        scaled;
  logic signed [15:0] value_full;

  assign out_take = !result_valid || !result_stall;
  assign s1_load  = !s1_valid || out_take;
  assign pop      = q_status.valid && s1_load;
  assign span     = head_job.kind ? HumSpan : TempSpan;

  assign scaled     = s1_prod[30:16];
  assign value_full = $signed({1'b0, scaled}) + (s1_kind ? HumOffset : TempOffset);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= q_status.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind   <= head_job.kind;
      s1_raw    <= head_job.raw;
      s1_crc_ok <= head_job.crc_ok;
      s1_prod   <= 31'(span * head_job.raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_take) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      result.measure_kind <= s1_kind;
      result.raw_reading  <= s1_raw;
      result.value_centi  <= value_full[14:0];
      result.crc_ok       <= s1_crc_ok;
    end
  end

  `SFCCS_ASSERT_NEXT(a_stage_forward, s1_valid && out_take, result_valid)

endmodule

// ===== rtl/sensor_frame_crc_check_and_scale_unit.sv =====
// Sensor reading frame checker: CRC-8 (0x31) over MSB/LSB, scaled output.
// Top level; uses sfccs_pkg, sfccs_front, sfccs_queue and sfccs_scale.
//
// Usage: frame bytes (MSB, LSB, CRC) enter on byte_valid/frame_byte; a
// transfer happens when byte_valid is high and byte_stall low. frame_first
// restarts the frame; func is latched with the MSB. On the CRC byte one
// result leaves on result_valid/result: the reading with its status bits
// cleared, the value in hundredths and a CRC match flag.
// Throughput: one byte per cycle while byte_stall is low. After the CRC
// byte transfer the result passes through the job queue, the product
// register (the multiply) and then the output register.
// While result_stall is high the result holds; the back end stops and the
// job queue (QueueDepth entries) absorbs frames, and byte_stall rises once
// it is full. Reset clears the frame position, the queue and the pipeline.
module sensor_frame_crc_check_and_scale_unit #(
  parameter int QueueDepth = sfccs_pkg::QueueDepthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  sfccs_pkg::in_item_t   frame_byte,
  output logic                  result_valid,
  input  logic                  result_stall,
  output sfccs_pkg::out_item_t  result
);
  import sfccs_pkg::*;

  logic          push;
  job_t          push_job;
  logic          pop;
  job_t          head_job;
  queue_status_t q_status;

  sfccs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .frame_byte (frame_byte),
    .queue_full (q_status.full),
    .push       (push),
    .push_job   (push_job)
  );

  sfccs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  sfccs_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head_job     (head_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for sensor_frame_crc_check_and_scale_unit: frames of MSB, LSB and CRC
// bytes with random gaps on both sides, each reading checked against an in-bench predictor.
// Depends on sfccs_pkg and the unit's RTL.
module tb;
  import sfccs_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int ByteTarget = 1350;
  localparam int LongHold = 400;

  // Tracks the frame position, predicts each reading and checks what comes out.
  class frame_tracker;
    logic [1:0] pos;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] crc;
    logic       kind;
    out_item_t  pending_readings[$];
    int bytes_in;
    int readings_seen;
    int bad_crc_seen;
    int hum_seen;
    int errors;

    function new();
      pos = 0;
      hi = 0;
      lo = 0;
      crc = 0;
      kind = 0;
      bytes_in = 0;
      readings_seen = 0;
      bad_crc_seen = 0;
      hum_seen = 0;
      errors = 0;
    endfunction

    // MSB-first CRC-8 step, polynomial 0x31, no reflection
    static function logic [7:0] crc8_step(logic [7:0] c, logic [7:0] b);
      logic [7:0] x;
      x = c ^ b;
      for (int k = 0; k < 8; k++) begin
        if (x[7]) x = (x << 1) ^ CrcPoly;
        else x = x << 1;
      end
      return x;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    function void take_byte(in_item_t it);
      out_item_t  want;
      logic [15:0] raw;
      logic [31:0] prod;
      int          v;
      bytes_in++;
      if (it.frame_first || pos == 0 || pos > 2) begin
        kind = it.func;
        hi = it.data_byte;
        crc = crc8_step(CrcInit, it.data_byte);
        pos = 1;
      end else if (pos == 1) begin
        lo = it.data_byte;
        crc = crc8_step(crc, it.data_byte);
        pos = 2;
      end else begin
        raw = {hi, lo} & ~StatusMask;
        if (kind) begin
          prod = 32'(HumSpan) * 32'(raw);
          v = int'(prod >> 16) + int'(HumOffset);
        end else begin
          prod = 32'(TempSpan) * 32'(raw);
          v = int'(prod >> 16) + int'(TempOffset);
        end
        want.measure_kind = kind;
        want.raw_reading = raw;
        want.value_centi = v[14:0];
        want.crc_ok = (crc == it.data_byte);
        if (!want.crc_ok) bad_crc_seen++;
        if (kind) hum_seen++;
        pending_readings.push_back(want);
        pos = 0;
      end
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= 10)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void match_reading(out_item_t got);
      out_item_t want;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        flag("unexpected reading raw", -1, got.raw_reading);
        return;
      end
      want = pending_readings.pop_front();
      if (got.measure_kind !== want.measure_kind)
        flag("measure_kind", want.measure_kind, got.measure_kind);
      if (got.raw_reading !== want.raw_reading)
        flag("raw_reading", want.raw_reading, got.raw_reading);
      if (got.value_centi !== want.value_centi)
        flag("value_centi", $signed(want.value_centi), $signed(got.value_centi));
      if (got.crc_ok !== want.crc_ok)
        flag("crc_ok", want.crc_ok, got.crc_ok);
    endfunction

    function void wrap_up();
      while (pending_readings.size() != 0) begin
        flag("missing reading raw", pending_readings[0].raw_reading, -1);
        void'(pending_readings.pop_front());
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_stall;
  in_item_t  frame_byte;
  logic      result_valid;
  logic      result_stall;
  out_item_t result;

  frame_tracker frames = new();
  bit send_quiet;
  int idle_cycles;

  sensor_frame_crc_check_and_scale_unit uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .frame_byte   (frame_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_item_t mk(bit f, bit ff, logic [7:0] b);
    in_item_t it;
    it.func = f;
    it.frame_first = ff;
    it.data_byte = b;
    return it;
  endfunction

  // Entered and left at a falling edge; one transfer per call.
  task automatic send_byte(in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    frame_byte <= it;
    forever begin
      @(posedge clk);
      if (!byte_stall) break;
    end
    frames.take_byte(it);
    @(negedge clk);
  endtask

  // func on the LSB and CRC bytes is noise that the unit must ignore
  task automatic send_frame(bit f, bit marked, logic [15:0] raw, bit good_crc);
    logic [7:0] c;
    c = frame_tracker::crc8_step(frame_tracker::crc8_step(CrcInit, raw[15:8]), raw[7:0]);
    if (!good_crc) c = c ^ (8'h01 << $urandom_range(0, 7));
    send_byte(mk(f, marked, raw[15:8]));
    send_byte(mk($urandom_range(0, 1), 1'b0, raw[7:0]));
    send_byte(mk($urandom_range(0, 1), 1'b0, c));
  endtask

  task automatic pause_until_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (frames.pending() != 0);
  endtask

  // receiving side
  initial begin : result_side
    int  hold;
    bit  quiet;
    bit  long_done;
    quiet = 0;
    long_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      if (!long_done && frames.readings_seen >= 120) begin
        hold = LongHold;
        long_done = 1;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        result_stall <= 1'b0;
      end
      forever begin
        @(posedge clk);
        if (result_valid) break;
      end
      frames.match_reading(result);
      @(negedge clk);
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : byte_side
    logic [15:0] raw;
    bit          paused;
    int          n;
    rst = 1'b1;
    byte_valid = 1'b0;
    frame_byte = '0;
    result_stall = 1'b0;
    send_quiet = 0;
    paused = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, status bits, bad CRC, unmarked start, restarts
    send_frame(1'b0, 1'b1, 16'h0000, 1'b1);
    send_frame(1'b1, 1'b1, 16'hFFFF, 1'b1);
    send_frame(1'b0, 1'b1, 16'hFFFF, 1'b0);
    send_frame(1'b1, 1'b0, 16'h8000, 1'b1);
    send_byte(mk(1'b0, 1'b1, 8'h12));
    send_frame(1'b1, 1'b1, 16'h665C, 1'b1);
    send_byte(mk(1'b0, 1'b1, 8'hAB));
    send_byte(mk(1'b1, 1'b0, 8'hCD));
    send_frame(1'b0, 1'b1, 16'h7FFC, 1'b1);

    // random: mostly well-formed frames, some noise bytes
    while (frames.bytes_in < ByteTarget) begin
      if (!paused && frames.bytes_in >= 700) begin
        pause_until_drained();
        paused = 1;
      end
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0: raw = 16'h0000;
          1: raw = 16'hFFFF;
          2: raw = 16'h0003;
          3: raw = 16'hFFFC;
          default: raw = 16'($urandom());
        endcase
        send_frame($urandom_range(0, 1), $urandom_range(0, 3) != 0, raw,
                   $urandom_range(0, 3) != 0);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n)
          send_byte(mk($urandom_range(0, 1), $urandom_range(0, 3) == 0, 8'($urandom())));
      end
    end

    byte_valid <= 1'b0;
    while (frames.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    frames.wrap_up();

    $display("Sent %0d frame bytes; checked %0d readings, %0d humidity, %0d with bad CRC.",
             frames.bytes_in, frames.readings_seen, frames.hum_seen, frames.bad_crc_seen);
    $display("Mismatches and missing or extra readings: %0d", frames.errors);
    if (frames.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sfccs_pkg.sv
rtl/sfccs_front.sv
rtl/sfccs_queue.sv
rtl/sfccs_scale.sv
rtl/sensor_frame_crc_check_and_scale_unit.sv
tb/tb.sv
